// ----- design/bhs_pkg.sv -----
// Shared types, constants and widths of the band history smoother.
package bhs_pkg;

    // Default sizing of the history store
    localparam int MAX_WINDOW_DEF = 16;
    localparam int MAX_BANDS_DEF  = 64;

    // Field widths
    localparam int BAND_W   = 6;
    localparam int VALUE_W  = 32;
    localparam int CURVE_W  = 2;
    localparam int WIN_W    = 5;
    localparam int EXPF_W   = 16;
    localparam int BCNT_W   = 7;
    localparam int WEIGHT_W = 24;

    // APB port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Curve codes
    localparam logic [CURVE_W-1:0] CURVE_FLAT   = 2'd0;
    localparam logic [CURVE_W-1:0] CURVE_LINEAR = 2'd1;
    localparam logic [CURVE_W-1:0] CURVE_EXP    = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_CURVE_MODE = 2'd0;
    localparam logic [1:0] REG_WINDOW_LEN = 2'd1;
    localparam logic [1:0] REG_EXP_FACTOR = 2'd2;
    localparam logic [1:0] REG_BAND_COUNT = 2'd3;

    // Register reset values
    localparam logic [CURVE_W-1:0] CURVE_MODE_RST = CURVE_EXP;
    localparam logic [WIN_W-1:0]   WINDOW_LEN_RST = 5'd4;
    localparam logic [EXPF_W-1:0]  EXP_FACTOR_RST = 16'd6144;
    localparam logic [BCNT_W-1:0]  BAND_COUNT_RST = 7'd64;

    // Exponential weight arithmetic, Q12.12
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 24'd4096;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 24'hFFFFFF;
    localparam int                  EXP_SHIFT  = 12;
    localparam int                  EXP_ROUND  = 2048;

    typedef struct packed {
        logic [CURVE_W-1:0] curve_mode;
        logic [WIN_W-1:0]   window_len;
        logic [EXPF_W-1:0]  exp_factor;
        logic [BCNT_W-1:0]  band_count;
    } bhs_cfg_t;

    typedef struct packed {
        logic clear_we;
        logic accept;
        logic issue;
        logic prep;
        logic div_step;
        logic load_out;
    } bhs_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic item_ok;
        logic item_pass;
        logic scan_last;
        logic pipe_busy;
        logic div_last;
    } bhs_stat_t;

endpackage

// ----- design/bhs_band_if.sv -----
// Input channel of the band history smoother: one band value per item.
interface bhs_band_if;
    logic                         valid;
    logic                         ready;
    logic [bhs_pkg::BAND_W-1:0]   band_index;
    logic [bhs_pkg::VALUE_W-1:0]  band_value;
    logic                         frame_start;

    modport source (
        output valid,
        output band_index,
        output band_value,
        output frame_start,
        input  ready
    );

    modport sink (
        input  valid,
        input  band_index,
        input  band_value,
        input  frame_start,
        output ready
    );
endinterface

// ----- design/bhs_result_if.sv -----
// Result channel of the band history smoother: one smoothed value per item.
interface bhs_result_if;
    logic                         valid;
    logic                         ready;
    logic [bhs_pkg::BAND_W-1:0]   out_band;
    logic [bhs_pkg::VALUE_W-1:0]  smoothed_value;

    modport source (
        output valid,
        output out_band,
        output smoothed_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_band,
        input  smoothed_value,
        output ready
    );
endinterface

// ----- design/bhs_regs.sv -----
// APB configuration registers of the band history smoother.
module bhs_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bhs_pkg::PADDR_W-1:0]  paddr,
    input  logic [bhs_pkg::PDATA_W-1:0]  pwdata,
    output logic [bhs_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output bhs_pkg::bhs_cfg_t            cfg
);

    bhs_pkg::bhs_cfg_t cfg_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[bhs_pkg::PADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Write the addressed register, keeping only its own bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.curve_mode <= bhs_pkg::CURVE_MODE_RST;
            cfg_reg.window_len <= bhs_pkg::WINDOW_LEN_RST;
            cfg_reg.exp_factor <= bhs_pkg::EXP_FACTOR_RST;
            cfg_reg.band_count <= bhs_pkg::BAND_COUNT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                bhs_pkg::REG_CURVE_MODE:
                    cfg_reg.curve_mode <= pwdata[bhs_pkg::CURVE_W-1:0];
                bhs_pkg::REG_WINDOW_LEN:
                    cfg_reg.window_len <= pwdata[bhs_pkg::WIN_W-1:0];
                bhs_pkg::REG_EXP_FACTOR:
                    cfg_reg.exp_factor <= pwdata[bhs_pkg::EXPF_W-1:0];
                bhs_pkg::REG_BAND_COUNT:
                    cfg_reg.band_count <= pwdata[bhs_pkg::BCNT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_idx)
            bhs_pkg::REG_CURVE_MODE: prdata = bhs_pkg::PDATA_W'(cfg_reg.curve_mode);
            bhs_pkg::REG_WINDOW_LEN: prdata = bhs_pkg::PDATA_W'(cfg_reg.window_len);
            bhs_pkg::REG_EXP_FACTOR: prdata = bhs_pkg::PDATA_W'(cfg_reg.exp_factor);
            bhs_pkg::REG_BAND_COUNT: prdata = bhs_pkg::PDATA_W'(cfg_reg.band_count);
            default:                 prdata = '0;
        endcase
    end

endmodule

// ----- design/bhs_ctrl.sv -----
// Sequencing state machine of the band history smoother.
module bhs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  bhs_pkg::bhs_stat_t stat,
    output bhs_pkg::bhs_cmd_t  cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DRAIN = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } bhs_state_t;

    bhs_state_t state_reg;
    bhs_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (!stat.item_ok)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (stat.item_pass)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    cmd.prep   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Hold the result until the sink takes it
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/bhs_dpath.sv -----
// History store, weighted accumulation and serial divider of the smoother.
module bhs_dpath #(
    parameter int MAX_WINDOW = bhs_pkg::MAX_WINDOW_DEF,
    parameter int MAX_BANDS  = bhs_pkg::MAX_BANDS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bhs_pkg::bhs_cfg_t            cfg,
    input  bhs_pkg::bhs_cmd_t            cmd,
    output bhs_pkg::bhs_stat_t           stat,
    input  logic [bhs_pkg::BAND_W-1:0]   band_index,
    input  logic [bhs_pkg::VALUE_W-1:0]  band_value,
    input  logic                         frame_start,
    output logic [bhs_pkg::BAND_W-1:0]   out_band,
    output logic [bhs_pkg::VALUE_W-1:0]  smoothed_value
);

    localparam int VW     = bhs_pkg::VALUE_W;
    localparam int WW     = bhs_pkg::WEIGHT_W;
    localparam int NW     = $clog2(MAX_WINDOW + 1);
    localparam int SW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DEPTH  = MAX_WINDOW * MAX_BANDS;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW     = $clog2(MAX_WINDOW) + 1;
    localparam int PROD_W = VW + WW;
    localparam int SUM_W  = PROD_W + LW;
    localparam int TOT_W  = WW + LW;
    localparam int NUM_W  = SUM_W + 1;
    localparam int EP_W   = WW + bhs_pkg::EXPF_W + 1;
    localparam int DCW    = $clog2(VW);

    // History store
    logic [VW-1:0]     hist_mem [DEPTH];
    logic [VW-1:0]     rd_data_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [VW-1:0]     wr_data;
    logic [AW-1:0]     item_addr;
    logic [AW-1:0]     rd_addr;

    // Item decode
    logic [NW-1:0]     n_eff;
    logic [NW-1:0]     cur_inc;
    logic [SW-1:0]     cur_new;
    logic [NW-1:0]     cur_p1;
    logic [SW-1:0]     scan_start;
    logic              band_ok;
    logic [SW-1:0]     slot_reg;

    // Item held during the scan
    logic [bhs_pkg::BAND_W-1:0] band_reg;
    logic [VW-1:0]     value_reg;
    logic              pass_reg;
    logic [NW-1:0]     n_reg;

    // Scan sequencing and weights
    logic [SW-1:0]     rd_slot_reg;
    logic [SW-1:0]     rd_slot_next;
    logic [NW-1:0]     step_reg;
    logic [NW-1:0]     lin_reg;
    logic [WW-1:0]     ew_reg;
    logic [WW-1:0]     ew_next;
    logic [EP_W-1:0]   ew_rnd;
    logic [WW-1:0]     w_issue;

    // Multiply and accumulate pipe
    logic              issue_d1_reg;
    logic              issue_d2_reg;
    logic [WW-1:0]     w_d1_reg;
    logic [WW-1:0]     w_d2_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [TOT_W-1:0]  total_reg;

    // Divider
    logic [NUM_W-1:0]  num;
    logic [TOT_W-1:0]  rem_reg;
    logic [VW-1:0]     quot_reg;
    logic [DCW-1:0]    div_cnt_reg;
    logic [TOT_W:0]    rem_shift;
    logic [TOT_W:0]    rem_trial;
    logic              q_bit;

    // Output register
    logic [bhs_pkg::BAND_W-1:0] out_band_reg;
    logic [VW-1:0]     out_value_reg;

    // Clamp the window and find the slot this item writes
    always_comb
    begin
        if (cfg.window_len == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(cfg.window_len) > MAX_WINDOW)
        begin
            n_eff = NW'(MAX_WINDOW);
        end
        else
        begin
            n_eff = NW'(cfg.window_len);
        end
        cur_inc    = NW'(slot_reg) + NW'(frame_start);
        cur_new    = (cur_inc >= n_eff) ? '0 : SW'(cur_inc);
        cur_p1     = NW'(cur_new) + NW'(1);
        scan_start = (cur_p1 >= n_eff) ? '0 : SW'(cur_p1);
        band_ok    = ({1'b0, band_index} < cfg.band_count) && (int'(band_index) < MAX_BANDS);
    end

    assign item_addr = AW'(cur_new) * AW'(MAX_BANDS) + AW'(band_index);
    assign rd_addr   = AW'(rd_slot_reg) * AW'(MAX_BANDS) + AW'(band_reg);

    // Store port: clearing sweep after reset, else the item's own write
    assign wr_en   = cmd.clear_we || (cmd.accept && band_ok);
    assign wr_addr = cmd.clear_we ? clr_addr_reg : item_addr;
    assign wr_data = cmd.clear_we ? '0 : band_value;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    // Pick the weight of the current step and grow the exponential one
    always_comb
    begin
        case (cfg.curve_mode)
            bhs_pkg::CURVE_LINEAR: w_issue = WW'(lin_reg);
            bhs_pkg::CURVE_EXP:    w_issue = ew_reg;
            default:               w_issue = WW'(1);
        endcase
        ew_rnd = EP_W'(ew_reg) * EP_W'(cfg.exp_factor) + EP_W'(bhs_pkg::EXP_ROUND);
        if ((ew_rnd >> bhs_pkg::EXP_SHIFT) > EP_W'(bhs_pkg::WEIGHT_MAX))
        begin
            ew_next = bhs_pkg::WEIGHT_MAX;
        end
        else
        begin
            ew_next = ew_rnd[bhs_pkg::EXP_SHIFT +: WW];
        end
        rd_slot_next = ((NW'(rd_slot_reg) + NW'(1)) >= n_reg) ? '0 : rd_slot_reg + SW'(1);
    end

    // Rounded numerator and one restoring division step
    always_comb
    begin
        num       = NUM_W'(sum_reg) + NUM_W'(total_reg >> 1);
        rem_shift = {rem_reg, quot_reg[VW-1]};
        q_bit     = (rem_shift >= {1'b0, total_reg});
        rem_trial = rem_shift - {1'b0, total_reg};
    end

    // Control state: slot pointer, sweep address, pipe valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= '0;
            clr_addr_reg <= '0;
            issue_d1_reg <= 1'b0;
            issue_d2_reg <= 1'b0;
            step_reg     <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.clear_we)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.accept)
            begin
                slot_reg <= cur_new;
                step_reg <= '0;
            end
            else if (cmd.issue)
            begin
                step_reg <= step_reg + NW'(1);
            end
            issue_d1_reg <= cmd.issue;
            issue_d2_reg <= issue_d1_reg;
            if (cmd.prep)
            begin
                div_cnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                div_cnt_reg <= div_cnt_reg + DCW'(1);
            end
        end
    end

    // Payload: item capture, scan weights, multiply-accumulate, divider, output
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            band_reg    <= band_index;
            value_reg   <= band_value;
            pass_reg    <= (n_eff == NW'(1));
            n_reg       <= n_eff;
            rd_slot_reg <= scan_start;
            lin_reg     <= NW'(1);
            ew_reg      <= bhs_pkg::WEIGHT_ONE;
            sum_reg     <= '0;
            total_reg   <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                rd_slot_reg <= rd_slot_next;
                lin_reg     <= lin_reg + NW'(1);
                ew_reg      <= ew_next;
            end
            if (issue_d2_reg)
            begin
                sum_reg   <= sum_reg + SUM_W'(prod_reg);
                total_reg <= total_reg + TOT_W'(w_d2_reg);
            end
        end
        w_d1_reg <= w_issue;
        w_d2_reg <= w_d1_reg;
        prod_reg <= PROD_W'(rd_data_reg) * PROD_W'(w_d1_reg);
        if (cmd.prep)
        begin
            rem_reg  <= num[VW +: TOT_W];
            quot_reg <= num[VW-1:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= q_bit ? rem_trial[TOT_W-1:0] : rem_shift[TOT_W-1:0];
            quot_reg <= {quot_reg[VW-2:0], q_bit};
        end
        if (cmd.load_out)
        begin
            out_band_reg  <= band_reg;
            out_value_reg <= pass_reg ? value_reg : quot_reg;
        end
    end

    // Status back to the controller
    assign stat.clear_last = (clr_addr_reg == AW'(DEPTH - 1));
    assign stat.item_ok    = band_ok;
    assign stat.item_pass  = (n_eff == NW'(1));
    assign stat.scan_last  = (step_reg == n_reg - NW'(1));
    assign stat.pipe_busy  = issue_d1_reg || issue_d2_reg;
    assign stat.div_last   = (div_cnt_reg == DCW'(VW - 1));

    assign out_band       = out_band_reg;
    assign smoothed_value = out_value_reg;

endmodule

// ----- design/band_history_smoother_core.sv -----
// Top level of the band history smoother: channels, APB registers, controller, datapath.
//
// Smooths each band's level over the last window_len frames (flat, linear or exponential
// weights, rounded weighted mean) and returns one item per accepted item whose band is in
// use. Items are handled one at a time: with a window of n >= 2 an item goes through n
// history reads through the single store read port, the multiply-accumulate drain and
// rounding, a one-bit-per-cycle divider and the load of the output register before the
// next item can be accepted; a window of one goes straight to the output register, and
// an item for an unused band yields no result. The output register lets the next item
// be accepted while a result still waits. After reset the history store is cleared one
// entry per cycle, all MAX_WINDOW * MAX_BANDS entries (1024 by default), with the input
// not ready; register writes are taken throughout.
module band_history_smoother_core #(
    parameter int MAX_WINDOW = bhs_pkg::MAX_WINDOW_DEF,
    parameter int MAX_BANDS  = bhs_pkg::MAX_BANDS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    bhs_band_if.sink                     band_ch,
    bhs_result_if.source                 result_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bhs_pkg::PADDR_W-1:0]  paddr,
    input  logic [bhs_pkg::PDATA_W-1:0]  pwdata,
    output logic [bhs_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    bhs_pkg::bhs_cfg_t  cfg;
    bhs_pkg::bhs_cmd_t  cmd;
    bhs_pkg::bhs_stat_t stat;

    // Configuration registers
    bhs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer
    bhs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (band_ch.valid),
        .in_ready  (band_ch.ready),
        .out_valid (result_ch.valid),
        .out_ready (result_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // History store and arithmetic
    bhs_dpath #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_BANDS  (MAX_BANDS)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .stat           (stat),
        .band_index     (band_ch.band_index),
        .band_value     (band_ch.band_value),
        .frame_start    (band_ch.frame_start),
        .out_band       (result_ch.out_band),
        .smoothed_value (result_ch.smoothed_value)
    );

endmodule

// ----- design/bhs_checker.sv -----
// Port-level checks of the band history smoother and their binding to the top level.
module bhs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [bhs_pkg::BAND_W-1:0]   out_band,
    input logic [bhs_pkg::VALUE_W-1:0]  out_value
);

    // A waiting result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped before it was taken");

    // A waiting result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_band) && $stable(out_value))
        else $error("result item changed while stalled");

    // No result appears in the cycle right after an item is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result item appeared too early");

    // The store is being cleared when reset lifts
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("input ready during clearing pass");

endmodule

bind band_history_smoother_core bhs_checker u_bhs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (band_ch.valid),
    .in_ready  (band_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_band  (result_ch.out_band),
    .out_value (result_ch.smoothed_value)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the band history smoother: directed table, then random frames.
module tb_top;

    localparam int BAND_W   = bhs_pkg::BAND_W;
    localparam int VALUE_W  = bhs_pkg::VALUE_W;
    localparam int CURVE_W  = bhs_pkg::CURVE_W;
    localparam int WIN_W    = bhs_pkg::WIN_W;
    localparam int EXPF_W   = bhs_pkg::EXPF_W;
    localparam int BCNT_W   = bhs_pkg::BCNT_W;
    localparam int WEIGHT_W = bhs_pkg::WEIGHT_W;
    localparam int PADDR_W  = bhs_pkg::PADDR_W;
    localparam int PDATA_W  = bhs_pkg::PDATA_W;

    localparam int MAX_WIN       = bhs_pkg::MAX_WINDOW_DEF;
    localparam int MAX_BANDS     = bhs_pkg::MAX_BANDS_DEF;
    localparam int HIST_DEPTH    = MAX_WIN * MAX_BANDS;
    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int REPORT_MAX    = 10;

    // Curve code 3 has no meaning of its own and smooths as flat
    localparam logic [CURVE_W-1:0] CURVE_SPARE = 2'd3;

    typedef struct {
        logic [BAND_W-1:0]  band;
        logic [VALUE_W-1:0] value;
    } smoothed_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [1:0]         reg_idx;
        logic [31:0]        reg_val;
        logic [BAND_W-1:0]  band;
        logic [VALUE_W-1:0] value;
        bit                 fs;
        bit                 typed;
        logic [VALUE_W-1:0] typed_val;
    } band_row_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    bhs_band_if   band_ch ();
    bhs_result_if result_ch ();

    band_history_smoother_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .band_ch   (band_ch),
        .result_ch (result_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Mirror of the block: history store, slot pointer, registers
    logic [VALUE_W-1:0] hist_mirror [HIST_DEPTH];
    logic [3:0]         slot_mirror;
    logic [CURVE_W-1:0] cfg_curve;
    logic [WIN_W-1:0]   cfg_win;
    logic [EXPF_W-1:0]  cfg_expf;
    logic [BCNT_W-1:0]  cfg_bcnt;

    smoothed_t smooth_due [$];
    band_row_t script [$];

    int miss_cnt;
    int cycle_cnt;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_req;
    bit hold_taken;

    always #2 clk = ~clk;

    // Update the mirror for one accepted item; return 1 if it yields a smoothed value
    function automatic bit smooth_predict(input logic [BAND_W-1:0] band,
                                          input logic [VALUE_W-1:0] value,
                                          input bit fs,
                                          output logic [VALUE_W-1:0] res);
        int          n;
        int          cur;
        int          first;
        int          slot;
        logic [63:0] acc;
        logic [63:0] wsum;
        logic [63:0] nxt;
        logic [63:0] lin;
        logic [WEIGHT_W-1:0] ew;
        n = int'(cfg_win);
        if (n == 0) n = 1;
        if (n > MAX_WIN) n = MAX_WIN;
        cur = int'(slot_mirror);
        if (fs) cur++;
        if (cur >= n) cur = 0;
        slot_mirror = cur[3:0];
        res = '0;
        if ({1'b0, band} >= cfg_bcnt) return 0;
        hist_mirror[cur * MAX_BANDS + band] = value;
        if (n == 1)
        begin
            res = value;
            return 1;
        end
        // Walk the ring from oldest to newest
        acc   = '0;
        wsum  = '0;
        lin   = 64'd1;
        ew    = bhs_pkg::WEIGHT_ONE;
        first = (cur + 1 >= n) ? 0 : cur + 1;
        for (int i = 0; i < n; i++)
        begin
            slot = first + i;
            if (slot >= n) slot -= n;
            if (cfg_curve == bhs_pkg::CURVE_LINEAR)
            begin
                acc  += 64'(hist_mirror[slot * MAX_BANDS + band]) * lin;
                wsum += lin;
                lin++;
            end
            else if (cfg_curve == bhs_pkg::CURVE_EXP)
            begin
                acc  += 64'(hist_mirror[slot * MAX_BANDS + band]) * 64'(ew);
                wsum += 64'(ew);
                nxt = (64'(ew) * 64'(cfg_expf) + 64'(bhs_pkg::EXP_ROUND)) >> bhs_pkg::EXP_SHIFT;
                ew  = (nxt > 64'(bhs_pkg::WEIGHT_MAX)) ? bhs_pkg::WEIGHT_MAX
                                                       : nxt[WEIGHT_W-1:0];
            end
            else
            begin
                acc  += 64'(hist_mirror[slot * MAX_BANDS + band]);
                wsum += 64'd1;
            end
        end
        res = VALUE_W'((acc + wsum / 2) / wsum);
        return 1;
    endfunction

    function automatic band_row_t item_row(input logic [BAND_W-1:0] band,
                                           input logic [VALUE_W-1:0] value, input bit fs);
        band_row_t r;
        r = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, band: band, value: value, fs: fs,
              typed: 1'b0, typed_val: '0};
        return r;
    endfunction

    function automatic band_row_t known_row(input logic [BAND_W-1:0] band,
                                            input logic [VALUE_W-1:0] value, input bit fs,
                                            input logic [VALUE_W-1:0] res);
        band_row_t r;
        r = item_row(band, value, fs);
        r.typed     = 1'b1;
        r.typed_val = res;
        return r;
    endfunction

    function automatic band_row_t reg_row(input logic [1:0] idx, input logic [31:0] val);
        band_row_t r;
        r = item_row('0, '0, 1'b0);
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Append one row to the end of the directed table
    function automatic void append_row(input band_row_t r);
        script.insert(script.size(), r);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return '0;
        if (sel == 1) return '1;
        if (sel == 2) return $urandom_range(255);
        return $urandom();
    endfunction

    // Write one register through the APB port: setup, then access, then idle
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bhs_pkg::REG_CURVE_MODE: cfg_curve = val[CURVE_W-1:0];
            bhs_pkg::REG_WINDOW_LEN: cfg_win   = val[WIN_W-1:0];
            bhs_pkg::REG_EXP_FACTOR: cfg_expf  = val[EXPF_W-1:0];
            bhs_pkg::REG_BAND_COUNT: cfg_bcnt  = val[BCNT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offer one item, hold it until taken, then queue its smoothed value if it yields one
    task automatic offer_band(input logic [BAND_W-1:0] band, input logic [VALUE_W-1:0] value,
                              input bit fs, input bit typed, input logic [VALUE_W-1:0] typed_val,
                              output bit produced);
        smoothed_t          e;
        logic [VALUE_W-1:0] r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            band_ch.valid <= 1'b0;
            @(posedge clk);
        end
        band_ch.valid       <= 1'b1;
        band_ch.band_index  <= band;
        band_ch.band_value  <= value;
        band_ch.frame_start <= fs;
        @(posedge clk);
        while (!band_ch.ready) @(posedge clk);
        produced = smooth_predict(band, value, fs, r);
        if (produced)
        begin
            e.band  = band;
            e.value = typed ? typed_val : r;
            smooth_due.insert(smooth_due.size(), e);
        end
    endtask

    // Drop valid, wait for every pending result, then let the block go quiet
    task automatic settle();
        band_ch.valid <= 1'b0;
        while (smooth_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic take_result();
        smoothed_t e;
        if (smooth_due.size() == 0)
        begin
            miss_cnt++;
            if (miss_cnt <= REPORT_MAX)
                $display("ERROR: band %0d value %h arrived with nothing expected",
                         result_ch.out_band, result_ch.smoothed_value);
        end
        else
        begin
            e = smooth_due.pop_front();
            if (e.band !== result_ch.out_band || e.value !== result_ch.smoothed_value)
            begin
                miss_cnt++;
                if (miss_cnt <= REPORT_MAX)
                    $display("ERROR: band exp %0d got %0d, value exp %h got %h",
                             e.band, result_ch.out_band, e.value, result_ch.smoothed_value);
            end
        end
    endtask

    // Result side: check each taken item, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            take_result();
        if (hold_left > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_left--;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus
    initial
    begin
        logic [CURVE_W-1:0] ph_curve [PHASES];
        int                 ph_win   [PHASES];
        int                 ph_expf  [PHASES];
        int                 ph_bcnt  [PHASES];
        bit                 got;
        bit                 hold_done;
        int                 made;
        int                 bands_used;
        int                 span;
        int                 base;

        ph_curve = '{bhs_pkg::CURVE_EXP, bhs_pkg::CURVE_LINEAR, bhs_pkg::CURVE_EXP, CURVE_SPARE,
                     bhs_pkg::CURVE_EXP, bhs_pkg::CURVE_FLAT, bhs_pkg::CURVE_EXP};
        ph_win   = '{16, 5, 4, 31, 3, 8, 1};
        ph_expf  = '{65535, -1, -1, -1, 0, -1, 6144};
        ph_bcnt  = '{64, 8, 3, 127, 1, 16, 64};

        clk                 = 1'b0;
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        band_ch.valid       = 1'b0;
        band_ch.band_index  = '0;
        band_ch.band_value  = '0;
        band_ch.frame_start = 1'b0;
        hold_done           = 1'b0;
        send_idle_pct       = 38;
        recv_idle_pct       = 48;
        foreach (hist_mirror[i]) hist_mirror[i] = '0;
        slot_mirror = '0;
        cfg_curve   = bhs_pkg::CURVE_MODE_RST;
        cfg_win     = bhs_pkg::WINDOW_LEN_RST;
        cfg_expf    = bhs_pkg::EXP_FACTOR_RST;
        cfg_bcnt    = bhs_pkg::BAND_COUNT_RST;

        // Directed table: reset defaults, every curve, window edges, unused bands
        append_row(known_row(6'd0, 32'h0, 1'b0, 32'h0));
        append_row(item_row(6'd63, 32'hFFFF_FFFF, 1'b1));
        append_row(item_row(6'd63, 32'h0, 1'b0));
        append_row(reg_row(bhs_pkg::REG_CURVE_MODE, 32'(bhs_pkg::CURVE_FLAT)));
        append_row(item_row(6'd10, 32'h0001_0000, 1'b1));
        append_row(item_row(6'd10, 32'h0003_0000, 1'b1));
        append_row(reg_row(bhs_pkg::REG_CURVE_MODE, 32'(bhs_pkg::CURVE_LINEAR)));
        append_row(item_row(6'd10, 32'h0005_0000, 1'b1));
        append_row(item_row(6'd10, 32'hFFFF_FFFF, 1'b1));
        append_row(reg_row(bhs_pkg::REG_CURVE_MODE, 32'(CURVE_SPARE)));
        append_row(item_row(6'd10, 32'h1234_5678, 1'b0));
        append_row(reg_row(bhs_pkg::REG_WINDOW_LEN, 32'd1));
        append_row(known_row(6'd7, 32'h1234_5678, 1'b1, 32'h1234_5678));
        append_row(known_row(6'd63, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF));
        append_row(reg_row(bhs_pkg::REG_WINDOW_LEN, 32'd0));
        append_row(known_row(6'd1, 32'hDEAD_BEEF, 1'b1, 32'hDEAD_BEEF));
        append_row(reg_row(bhs_pkg::REG_CURVE_MODE, 32'(bhs_pkg::CURVE_EXP)));
        append_row(reg_row(bhs_pkg::REG_EXP_FACTOR, 32'd65535));
        append_row(reg_row(bhs_pkg::REG_WINDOW_LEN, 32'd31));
        append_row(item_row(6'd2, 32'hFFFF_FFFF, 1'b1));
        append_row(item_row(6'd2, 32'h0, 1'b1));
        append_row(item_row(6'd2, 32'h8000_0000, 1'b1));
        append_row(item_row(6'd2, 32'hFFFF_FFFF, 1'b1));
        append_row(item_row(6'd2, 32'h1, 1'b1));
        append_row(reg_row(bhs_pkg::REG_EXP_FACTOR, 32'd0));
        append_row(item_row(6'd2, 32'h0010_0000, 1'b1));
        append_row(item_row(6'd2, 32'h7, 1'b0));
        // Shrinking the window leaves the slot pointer past its end
        append_row(reg_row(bhs_pkg::REG_WINDOW_LEN, 32'd4));
        append_row(item_row(6'd3, 32'h0000_ABCD, 1'b0));
        append_row(reg_row(bhs_pkg::REG_BAND_COUNT, 32'd1));
        append_row(item_row(6'd1, 32'h5, 1'b1));
        append_row(item_row(6'd63, 32'h9, 1'b1));
        append_row(item_row(6'd0, 32'h9, 1'b0));
        append_row(reg_row(bhs_pkg::REG_BAND_COUNT, 32'd0));
        append_row(item_row(6'd0, 32'hFFFF_FFFF, 1'b1));
        append_row(reg_row(bhs_pkg::REG_BAND_COUNT, 32'd127));
        append_row(item_row(6'd63, 32'h5555_5555, 1'b0));

        // Release reset
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            if (script[i].kind == ROW_REG)
            begin
                settle();
                reg_write(script[i].reg_idx, script[i].reg_val);
            end
            else
                offer_band(script[i].band, script[i].value, script[i].fs,
                           script[i].typed, script[i].typed_val, got);
        end

        // Random phases: mostly well-formed frames over a few bands, some noise
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 3)
            begin
                send_idle_pct = 38;
                recv_idle_pct = 48;
            end
            else if (p < 5)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 38;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            reg_write(bhs_pkg::REG_CURVE_MODE, 32'(ph_curve[p]));
            reg_write(bhs_pkg::REG_WINDOW_LEN, ph_win[p]);
            reg_write(bhs_pkg::REG_EXP_FACTOR,
                      (ph_expf[p] < 0) ? $urandom_range(65535) : ph_expf[p]);
            reg_write(bhs_pkg::REG_BAND_COUNT, ph_bcnt[p]);
            bands_used = (ph_bcnt[p] > MAX_BANDS) ? MAX_BANDS : ph_bcnt[p];
            span = $urandom_range(1, (bands_used < 6) ? bands_used : 6);
            base = $urandom_range(0, bands_used - span);
            made = 0;
            while (made < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 15)
                begin
                    offer_band(BAND_W'($urandom_range(MAX_BANDS - 1)), pick_value(),
                               $urandom_range(4) == 0, 1'b0, '0, got);
                    made += got;
                end
                else
                begin
                    for (int b = 0; b < span; b++)
                    begin
                        offer_band(BAND_W'(base + b), pick_value(), b == 0, 1'b0, '0, got);
                        made += got;
                    end
                end
                // Move the frame to other bands now and then
                if ($urandom_range(9) == 0)
                begin
                    span = $urandom_range(1, (bands_used < 6) ? bands_used : 6);
                    base = $urandom_range(0, bands_used - span);
                end
                // Stall the result side for a long stretch while items keep coming
                if (p == 1 && !hold_done && made >= 40)
                begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
            end
        end

        settle();
        if (miss_cnt == 0 && smooth_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
